[hdl/stream_id_slot_table_top_defines.svh]
// Assertion macros shared by the stream slot table RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef STREAM_ID_SLOT_TABLE_TOP_DEFINES_SVH
`define STREAM_ID_SLOT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication checked at every rising edge out of reset.
`define SIDST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every rising edge out of reset.
`define SIDST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sidst_pkg.sv]
// Shared constants for the stream slot table: table size, field widths
// and command codes. No dependencies.
package sidst_pkg;

    // Number of stream slots in the table.
    localparam int SLOT_COUNT = 16;

    // Field widths.
    localparam int ID_W    = 32;
    localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Command codes carried by an input beat.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

endpackage

[hdl/sidst_channels.sv]
// Valid/ready channel interfaces for the stream slot table input and output.
// Depends on sidst_pkg for field widths.
interface sidst_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [sidst_pkg::ID_W-1:0]    id_value;
    logic [sidst_pkg::ID_W-1:0]    random_word;

    modport source (output valid, output command, output id_value, output random_word,
                    input ready);
    modport sink   (input valid, input command, input id_value, input random_word,
                    output ready);
endinterface

interface sidst_out_if;
    logic                          valid;
    logic                          ready;
    logic [sidst_pkg::ID_W-1:0]    result_id;
    logic                          close_hit;
    logic [sidst_pkg::COUNT_W-1:0] active_count;

    modport source (output valid, output result_id, output close_hit, output active_count,
                    input ready);
    modport sink   (input valid, input result_id, input close_hit, input active_count,
                    output ready);
endinterface

[hdl/stream_id_slot_table_top.sv]
// Stream slot table: allocates and closes stream identifiers in a small table.
// Depends on sidst_pkg, sidst_channels.sv and stream_id_slot_table_top_defines.svh.
//
// Usage:
//   i_in carries one command beat: allocate (optionally with a requested
//   identifier, plus a random word) or close by identifier. o_out returns
//   exactly one beat per input beat: the assigned identifier, a close-hit
//   flag and the number of active slots after the command.
//   A single identifier comparator walks the slots one per cycle. A beat with
//   a nonzero identifier first scans for a matching active slot, and an
//   allocate that finds none, or that gives identifier zero, then scans for
//   the first free slot. A close of identifier zero skips both scans. The
//   result is loaded into the output register once it is free, and i_in.ready
//   returns in the same cycle, so the next beat is taken only after the
//   previous result has left the sequencer.
//   While the receiver stalls, the output register holds its result, the
//   next beat is accepted and scanned, and its result waits in the sequencer.
//   Reset (synchronous, active low) clears all active bits, the count and the
//   output valid; stored identifiers are only read while their slot is active.
`include "stream_id_slot_table_top_defines.svh"

module stream_id_slot_table_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sidst_in_if.sink          i_in,
    sidst_out_if.source       o_out
);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MATCH = 4'b0010,
        ST_FREE  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    localparam logic [sidst_pkg::IDX_W-1:0] LAST_IDX = sidst_pkg::IDX_W'(sidst_pkg::SLOT_COUNT - 1);
    localparam logic [sidst_pkg::ID_W-1:0]  ID_ONE   = sidst_pkg::ID_W'(1);

    t_state                            r_state, n_state;
    logic [sidst_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic                              r_cmd, n_cmd;
    logic [sidst_pkg::ID_W-1:0]        r_id, n_id;
    logic [sidst_pkg::ID_W-1:0]        r_rnd, n_rnd;
    logic [sidst_pkg::SLOT_COUNT-1:0]  r_active, n_active;
    logic [sidst_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [sidst_pkg::ID_W-1:0]        r_res_id, n_res_id;
    logic                              r_res_hit, n_res_hit;
    logic                              r_out_valid, n_out_valid;
    logic [sidst_pkg::ID_W-1:0]        r_out_id, n_out_id;
    logic                              r_out_hit, n_out_hit;
    logic [sidst_pkg::COUNT_W-1:0]     r_out_count, n_out_count;

    // Identifier storage, written only when a slot becomes active.
    logic [sidst_pkg::ID_W-1:0]        r_slot_id [sidst_pkg::SLOT_COUNT];
    logic                              id_we;

    logic                              slot_hit;
    logic [sidst_pkg::ID_W-1:0]        new_id;
    logic                              out_free;

    // The shared comparator looks at the slot under the scan index.
    assign slot_hit = r_active[r_idx] && (r_slot_id[r_idx] == r_id);

    // Identifier an allocate stores: requested one, else random with zero mapped to one.
    assign new_id = (r_id != '0) ? r_id : ((r_rnd != '0) ? r_rnd : ID_ONE);

    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.result_id    = r_out_id;
    assign o_out.close_hit    = r_out_hit;
    assign o_out.active_count = r_out_count;

    // Sequencer and scan control.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_rnd       = r_rnd;
        n_active    = r_active;
        n_count     = r_count;
        n_res_id    = r_res_id;
        n_res_hit   = r_res_hit;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_id    = r_out_id;
        n_out_hit   = r_out_hit;
        n_out_count = r_out_count;
        id_we       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_cmd     = i_in.command;
                    n_id      = i_in.id_value;
                    n_rnd     = i_in.random_word;
                    n_idx     = '0;
                    n_res_id  = '0;
                    n_res_hit = 1'b0;
                    if (i_in.id_value != '0) begin
                        n_state = ST_MATCH;
                    end else if (i_in.command == sidst_pkg::CMD_CLOSE) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_FREE;
                    end
                end
            end
            ST_MATCH: begin
                if (slot_hit) begin
                    if (r_cmd == sidst_pkg::CMD_CLOSE) begin
                        n_active[r_idx] = 1'b0;
                        n_count         = (r_count != '0) ? r_count - 1'b1 : r_count;
                        n_res_hit       = 1'b1;
                    end else begin
                        n_res_id = r_id;
                    end
                    n_state = ST_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = (r_cmd == sidst_pkg::CMD_CLOSE) ? ST_DONE : ST_FREE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FREE: begin
                if (!r_active[r_idx]) begin
                    n_active[r_idx] = 1'b1;
                    id_we           = 1'b1;
                    n_count         = r_count + 1'b1;
                    n_res_id        = new_id;
                    n_state         = ST_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_res_id;
                    n_out_hit   = r_res_hit;
                    n_out_count = r_count;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_id        <= n_id;
        r_rnd       <= n_rnd;
        r_res_id    <= n_res_id;
        r_res_hit   <= n_res_hit;
        r_out_id    <= n_out_id;
        r_out_hit   <= n_out_hit;
        r_out_count <= n_out_count;
    end

    // Identifier store write port.
    always_ff @(posedge i_clk) begin
        if (id_we) begin
            r_slot_id[r_idx] <= new_id;
        end
    end

    // The count always tracks the number of active slots.
    `SIDST_ASSERT_NOW(a_count_matches, 1'b1, r_count == sidst_pkg::COUNT_W'($countones(r_active)), "active count differs from active slots")
    // A close that hits never reports an identifier.
    `SIDST_ASSERT_NOW(a_close_no_id, o_out.valid && o_out.close_hit, o_out.result_id == '0, "close result carries an identifier")
    // An accepted beat starts the sequencer.
    `SIDST_ASSERT_NEXT(a_accept_busy, i_in.valid && i_in.ready, r_state != ST_IDLE, "sequencer idle after accepting a beat")
    // Only allocates scan for a free slot.
    `SIDST_ASSERT_NOW(a_free_alloc, r_state == ST_FREE, r_cmd == sidst_pkg::CMD_ALLOC, "free scan on a close command")

endmodule
